FILE: rtl/core/modbus_rtu_read_register_slave_macros.svh
// Assertion helpers for the asserting files
`ifndef MODBUS_RTU_READ_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_READ_REGISTER_SLAVE_MACROS_SVH

// Same-cycle implication, muted during reset
`define MBRTU_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mbrtu assertion failed");

// Next-cycle implication, muted during reset
`define MBRTU_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mbrtu assertion failed");

`endif

FILE: rtl/core/mbrtu_pkg.sv
package mbrtu_pkg;

  // Operation codes of an input item
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame constants
  localparam logic [7:0] ADDR_RESET      = 8'h08;
  localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0] REPLY_COUNT     = 8'h02;
  localparam logic [7:0] REG_TEMPERATURE = 8'h01;

  // Positions of the request tail (bytes after the address)
  localparam logic [2:0] TAIL_REG_LO   = 3'd2;
  localparam logic [2:0] TAIL_CRC_LO   = 3'd5;
  localparam logic [2:0] TAIL_LAST     = 3'd6;
  localparam logic [2:0] TAIL_CRC_SPAN = 3'd5;

  // Positions in the reply frame
  localparam logic [2:0] TX_IDX_ADDR   = 3'd0;
  localparam logic [2:0] TX_IDX_FUNC   = 3'd1;
  localparam logic [2:0] TX_IDX_COUNT  = 3'd2;
  localparam logic [2:0] TX_IDX_VAL_HI = 3'd3;
  localparam logic [2:0] TX_IDX_VAL_LO = 3'd4;
  localparam logic [2:0] TX_IDX_CRC_LO = 3'd5;
  localparam logic [2:0] TX_IDX_CRC_HI = 3'd6;

  // Configuration register indexes
  localparam logic REG_IDX_SLAVE_ADDR = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_byte;
    logic [15:0] new_temperature;
    logic [15:0] new_humidity;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_readings;
    logic       start_frame;
    logic       take_byte;
    logic       latch_reply;
    logic       load_out;
    logic [2:0] index;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic addr_match;
    logic crc_good;
    logic out_free;
  } dp_status_t;

  // One byte through the reflected CRC, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/mbrtu_ctrl.sv
module mbrtu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 operation,
  input  mbrtu_pkg::dp_status_t status,
  output logic                 item_ready,
  output mbrtu_pkg::dp_cmd_t   cmd
);
  import mbrtu_pkg::*;

  localparam logic [1:0] ST_HUNT    = 2'd0;
  localparam logic [1:0] ST_COLLECT = 2'd1;
  localparam logic [1:0] ST_REPLY   = 2'd2;

  logic [1:0] state, state_next;
  logic [2:0] count, count_next;
  logic       accept;

  assign item_ready = (state != ST_REPLY);
  assign accept     = item_valid && item_ready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    cmd.index  = count;
    case (state)
      ST_HUNT: begin
        if (accept) begin
          if (operation == OP_LOAD) begin
            cmd.load_readings = 1'b1;
          end else if (status.addr_match) begin
            cmd.start_frame = 1'b1;
            state_next      = ST_COLLECT;
            count_next      = '0;
          end
        end
      end
      ST_COLLECT: begin
        if (accept) begin
          if (operation == OP_LOAD) begin
            cmd.load_readings = 1'b1;
          end else begin
            cmd.take_byte = 1'b1;
            if (count == TAIL_LAST) begin
              count_next = '0;
              if (status.crc_good) begin
                cmd.latch_reply = 1'b1;
                state_next      = ST_REPLY;
              end else begin
                state_next = ST_HUNT;
              end
            end else begin
              count_next = count + 3'd1;
            end
          end
        end
      end
      ST_REPLY: begin
        // one reply byte each time the output register frees up
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (count == TX_IDX_CRC_HI) begin
            count_next = '0;
            state_next = ST_HUNT;
          end else begin
            count_next = count + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

FILE: rtl/core/mbrtu_dp.sv
module mbrtu_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  mbrtu_pkg::in_item_t  item,
  input  logic [7:0]           slave_address,
  input  mbrtu_pkg::dp_cmd_t   cmd,
  input  logic                 reply_ready,
  output mbrtu_pkg::dp_status_t status,
  output logic                 reply_valid,
  output mbrtu_pkg::out_item_t reply
);
  import mbrtu_pkg::*;

  logic [15:0] run_crc;
  logic [15:0] tx_crc;
  logic [15:0] temperature_reading;
  logic [15:0] humidity_reading;
  logic [15:0] value_q;
  logic [7:0]  reg_lo_q;
  logic [7:0]  crc_lo_q;
  logic [7:0]  tx_sel;

  // Status back to the controller
  assign status.addr_match = (item.rx_byte == slave_address);
  assign status.crc_good   = (crc_lo_q == run_crc[7:0]) && (item.rx_byte == run_crc[15:8]);
  assign status.out_free   = !reply_valid || reply_ready;

  // Reply byte for the current frame position
  always_comb begin
    case (cmd.index)
      TX_IDX_ADDR:   tx_sel = slave_address;
      TX_IDX_FUNC:   tx_sel = FUNC_READ_INPUT;
      TX_IDX_COUNT:  tx_sel = REPLY_COUNT;
      TX_IDX_VAL_HI: tx_sel = value_q[15:8];
      TX_IDX_VAL_LO: tx_sel = value_q[7:0];
      TX_IDX_CRC_LO: tx_sel = tx_crc[7:0];
      TX_IDX_CRC_HI: tx_sel = tx_crc[15:8];
      default:       tx_sel = tx_crc[15:8];
    endcase
  end

  // Sensor readings
  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_reading <= '0;
      humidity_reading    <= '0;
    end else if (cmd.load_readings) begin
      temperature_reading <= item.new_temperature;
      humidity_reading    <= item.new_humidity;
    end
  end

  // Request CRC and the kept tail bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      run_crc <= CRC_INIT;
    end else if (cmd.start_frame) begin
      run_crc <= crc_byte(CRC_INIT, item.rx_byte);
    end else if (cmd.take_byte && (cmd.index < TAIL_CRC_SPAN)) begin
      run_crc <= crc_byte(run_crc, item.rx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && (cmd.index == TAIL_REG_LO)) begin
      reg_lo_q <= item.rx_byte;
    end
    if (cmd.take_byte && (cmd.index == TAIL_CRC_LO)) begin
      crc_lo_q <= item.rx_byte;
    end
  end

  // Reply value and reply CRC, folded over the five bytes ahead of the CRC
  always_ff @(posedge clk) begin
    if (cmd.latch_reply) begin
      value_q <= (reg_lo_q == REG_TEMPERATURE) ? temperature_reading : humidity_reading;
      tx_crc  <= CRC_INIT;
    end else if (cmd.load_out && (cmd.index < TX_IDX_CRC_LO)) begin
      tx_crc  <= crc_byte(tx_crc, tx_sel);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      reply.tx_byte   <= tx_sel;
      reply.last_byte <= (cmd.index == TX_IDX_CRC_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (cmd.load_out) begin
      reply_valid <= 1'b1;
    end else if (reply_ready) begin
      reply_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/modbus_rtu_read_register_slave.sv
// Channel   Handshake                     Payload
// item      item_valid / item_ready       item  (operation, rx_byte, readings)
// reply     reply_valid / reply_ready     reply (tx_byte, last_byte)
// config    psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// The CRC of an input byte is folded in the same cycle in which the byte is taken.
// A good request gives seven reply bytes, one per cycle from the output register while
// reply_ready stays high, during which no item is taken.
// Synchronous active-high reset: hunting for the address, readings zero, address 0x08.
// A stalled reply holds the sequencer; once the last byte sits in the output
// register, items are taken again.
`include "modbus_rtu_read_register_slave_macros.svh"

module modbus_rtu_read_register_slave (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  mbrtu_pkg::in_item_t  item,
  output logic                 reply_valid,
  input  logic                 reply_ready,
  output mbrtu_pkg::out_item_t reply,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mbrtu_pkg::*;

  logic [7:0] slave_address;
  logic       reg_hit;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_IDX_SLAVE_ADDR);
  assign prdata  = reg_hit ? {24'h000000, slave_address} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= ADDR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      slave_address <= pwdata[7:0];
    end
  end

  mbrtu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (item.operation),
    .status     (status),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  mbrtu_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .slave_address (slave_address),
    .cmd           (cmd),
    .reply_ready   (reply_ready),
    .status        (status),
    .reply_valid   (reply_valid),
    .reply         (reply)
  );

  // While replying with the output register empty, a byte is loaded next cycle
  `MBRTU_ASSERT_NEXT(a_reply_fills, clk, rst, !item_ready && !reply_valid, reply_valid)
  // A stalled reply byte stays put until it is taken
  `MBRTU_ASSERT_NEXT(a_reply_holds, clk, rst, reply_valid && !reply_ready, reply_valid && $stable(reply))
  // Loading a reply byte never coincides with taking a request byte
  `MBRTU_ASSERT_SAME(a_no_overlap, clk, rst, cmd.load_out, !cmd.take_byte && !cmd.start_frame)

endmodule
